[hdl/svn_pkg.sv]
// package for the scaled vector normaliser
// holds transaction payload types, register indexes and fixed sizes; no dependencies
`default_nettype none
package svn_pkg;

  localparam int unsigned NumFields = 4;
  localparam int unsigned MaxDims   = 4;
  localparam int unsigned DimsCap   = (MaxDims < NumFields) ? MaxDims : NumFields;
  localparam int unsigned VmaxW     = 31;
  localparam int unsigned DimsW     = 3;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned MagW      = 32;
  localparam int unsigned ProdW     = VmaxW + MagW - 1;  // vmax * |d| stays below 2^62
  localparam int unsigned SqW       = 2 * MagW;
  localparam int unsigned SumW      = SqW + 1;
  localparam int unsigned RootStgs  = 33;                // root bits
  localparam int unsigned RootW     = SumW + 1;
  localparam int unsigned NormW     = RootStgs;
  localparam int unsigned QuotW     = VmaxW;

  localparam logic [CfgIdxW-1:0] RegVmax = 2'd0;
  localparam logic [CfgIdxW-1:0] RegMode = 2'd1;
  localparam logic [CfgIdxW-1:0] RegDims = 2'd2;

  localparam logic [VmaxW-1:0] VmaxRst = 31'd65536;
  localparam logic [DimsW-1:0] DimsRst = 3'd4;

  typedef struct packed {
    logic signed [31:0] d3;
    logic signed [31:0] d2;
    logic signed [31:0] d1;
    logic signed [31:0] d0;
  } svn_in_t;

  typedef struct packed {
    logic signed [31:0] u3;
    logic signed [31:0] u2;
    logic signed [31:0] u1;
    logic signed [31:0] u0;
  } svn_out_t;

endpackage
`default_nettype wire

[hdl/scaled_vector_normalize_core.sv]
// Scaled vector normaliser: one transaction in and one out per clock. The
// pipeline is an input stage, squares/product, sum, 33 square-root stages (one
// root bit each), 31 divider stages (one quotient bit each) and an output
// register. The whole pipeline advances together; it holds while the output is
// stalled, so one vector per cycle is sustained whenever the consumer keeps up.
// Registers: 0 vmax (unsigned Q15.16), 1 mode (1 negates), 2 dims_used.
// depends on svn_pkg
`default_nettype none
module scaled_vector_normalize_core
  import svn_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire svn_in_t              in_data_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output svn_out_t                  out_data_o,
  input  wire logic                 cfg_we_i,
  input  wire logic [CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [VmaxW-1:0]     cfg_wdata_i
);

  localparam int unsigned DivStgs = QuotW;
  localparam int unsigned NStg    = 3 + RootStgs + DivStgs + 1;

  logic [VmaxW-1:0] vmax_q;
  logic             mode_q;
  logic [DimsW-1:0] dims_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vmax_q <= VmaxRst;
      mode_q <= 1'b0;
      dims_q <= DimsRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegVmax: vmax_q <= cfg_wdata_i;
        RegMode: mode_q <= cfg_wdata_i[0];
        RegDims: dims_q <= cfg_wdata_i[DimsW-1:0];
        default: ;
      endcase
    end
  end

  logic            adv;
  logic [NStg-1:0] vld_q;

  assign adv         = !vld_q[NStg-1] || !out_stall_i;
  assign in_stall_o  = !adv;
  assign out_valid_o = vld_q[NStg-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NStg-2:0], in_valid_i};
    end
  end

  // stage a: magnitudes, signs, lanes in use
  logic [DimsW-1:0]          lim;
  logic [NumFields-1:0][31:0] din;
  logic [MagW-1:0]           mag_q [NumFields];
  logic [NumFields-1:0]      sgn_q;
  logic [NumFields-1:0]      use_q;

  always_comb begin
    lim = dims_q;
    if (lim == '0) lim = DimsW'(1);
    if (lim > DimsW'(DimsCap)) lim = DimsW'(DimsCap);
  end

  assign din = in_data_i;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < NumFields; k++) begin
        mag_q[k] <= din[k][31] ? (MagW'(0) - din[k]) : din[k];
        sgn_q[k] <= din[k][31] ^ mode_q;
        use_q[k] <= (k < int'(lim));
      end
    end
  end

  // stage b: squares and scaled magnitudes
  logic [SqW-1:0]       sq_q   [NumFields];
  logic [ProdW-1:0]     prb_q  [NumFields];
  logic [NumFields-1:0] sgnb_q;
  logic [NumFields-1:0] useb_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < NumFields; k++) begin
        sq_q[k]  <= use_q[k] ? (SqW'(mag_q[k]) * SqW'(mag_q[k])) : '0;
        prb_q[k] <= ProdW'(ProdW'(vmax_q) * ProdW'(mag_q[k]));
      end
      sgnb_q <= sgn_q;
      useb_q <= use_q;
    end
  end

  // stage c: sum of squares
  logic [SumW-1:0]      sum_q;
  logic [ProdW-1:0]     prc_q  [NumFields];
  logic [NumFields-1:0] sgnc_q;
  logic [NumFields-1:0] usec_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sum_q  <= SumW'(sq_q[0]) + SumW'(sq_q[1]) + SumW'(sq_q[2]) + SumW'(sq_q[3]);
      prc_q  <= prb_q;
      sgnc_q <= sgnb_q;
      usec_q <= useb_q;
    end
  end

  // square root, one root bit per stage, remainder method
  logic [RootW-1:0]     rr_q  [RootStgs];
  logic [RootW-1:0]     rs_q  [RootStgs];
  logic [ProdW-1:0]     rp_q  [RootStgs][NumFields];
  logic [NumFields-1:0] rsg_q [RootStgs];
  logic [NumFields-1:0] ru_q  [RootStgs];

  always_ff @(posedge clk_i) begin
    logic [RootW-1:0] rem, res, bt, t;
    if (adv) begin
      for (int j = 0; j < RootStgs; j++) begin
        if (j == 0) begin
          rem = RootW'(sum_q);
          res = '0;
        end else begin
          rem = rr_q[j-1];
          res = rs_q[j-1];
        end
        bt = RootW'(1) << (2 * (RootStgs - 1 - j));
        t  = res + bt;
        if (rem >= t) begin
          rr_q[j] <= rem - t;
          rs_q[j] <= (res >> 1) + bt;
        end else begin
          rr_q[j] <= rem;
          rs_q[j] <= res >> 1;
        end
        if (j == 0) begin
          rp_q[j]  <= prc_q;
          rsg_q[j] <= sgnc_q;
          ru_q[j]  <= usec_q;
        end else begin
          rp_q[j]  <= rp_q[j-1];
          rsg_q[j] <= rsg_q[j-1];
          ru_q[j]  <= ru_q[j-1];
        end
      end
    end
  end

  // restoring divider, one quotient bit per stage in each lane
  logic [NormW-1:0]     dn_q  [DivStgs];
  logic [ProdW-1:0]     dr_q  [DivStgs][NumFields];
  logic [QuotW-1:0]     dq_q  [DivStgs][NumFields];
  logic [NumFields-1:0] dsg_q [DivStgs];
  logic [NumFields-1:0] du_q  [DivStgs];

  always_ff @(posedge clk_i) begin
    logic [NormW-1:0] nrm;
    logic [ProdW-1:0] rem;
    logic [QuotW-1:0] quo;
    logic [SqW-1:0]   dsh;
    if (adv) begin
      for (int i = 0; i < DivStgs; i++) begin
        nrm = (i == 0) ? NormW'(rs_q[RootStgs-1]) : dn_q[i-1];
        dsh = SqW'(nrm) << (DivStgs - 1 - i);
        for (int k = 0; k < NumFields; k++) begin
          rem = (i == 0) ? rp_q[RootStgs-1][k] : dr_q[i-1][k];
          quo = (i == 0) ? '0 : dq_q[i-1][k];
          if (SqW'(rem) >= dsh) begin
            dr_q[i][k] <= ProdW'(SqW'(rem) - dsh);
            dq_q[i][k] <= quo | (QuotW'(1) << (DivStgs - 1 - i));
          end else begin
            dr_q[i][k] <= rem;
            dq_q[i][k] <= quo;
          end
        end
        dn_q[i]  <= nrm;
        dsg_q[i] <= (i == 0) ? rsg_q[RootStgs-1] : dsg_q[i-1];
        du_q[i]  <= (i == 0) ? ru_q[RootStgs-1] : du_q[i-1];
      end
    end
  end

  // output register: zero norm and unused lanes give zero
  logic [NumFields-1:0][31:0] o_q;

  always_ff @(posedge clk_i) begin
    logic [31:0] q;
    if (adv) begin
      for (int k = 0; k < NumFields; k++) begin
        q = 32'(dq_q[DivStgs-1][k]);
        if (dn_q[DivStgs-1] == '0 || !du_q[DivStgs-1][k]) begin
          o_q[k] <= '0;
        end else begin
          o_q[k] <= dsg_q[DivStgs-1][k] ? (32'd0 - q) : q;
        end
      end
    end
  end

  assign out_data_o = o_q;

endmodule
`default_nettype wire

[tb/sv/scaled_vector_normalize_core_tb.sv]
// self-checking testbench for scaled_vector_normalize_core
// predicts every output transaction and checks it in order; depends on svn_pkg
`timescale 1ns / 100ps
`default_nettype none

class norm_scoreboard;
  svn_pkg::svn_out_t expected_q[$];
  logic [30:0] vmax_r;
  logic        mode_r;
  logic [2:0]  dims_r;
  int unsigned errors;
  int unsigned checked;
  int unsigned zero_norms;

  function new();
    vmax_r = 31'd65536;
    mode_r = 1'b0;
    dims_r = 3'd4;
    errors = 0;
    checked = 0;
    zero_norms = 0;
  endfunction

  function void set_reg(logic [1:0] idx, logic [30:0] val);
    case (idx)
      svn_pkg::RegVmax: vmax_r = val;
      svn_pkg::RegMode: mode_r = val[0];
      svn_pkg::RegDims: dims_r = val[2:0];
      default: ;
    endcase
  endfunction

  // integer (floor) norm, then vmax * |d| / norm truncated toward zero
  function void note_input(svn_pkg::svn_in_t item);
    logic [31:0] comp [4];
    logic [31:0] mag [4];
    logic        neg [4];
    logic [65:0] sum_sq;
    logic [34:0] root;
    logic [34:0] cand;
    logic [69:0] cand_sq;
    logic [63:0] quot;
    logic [31:0] res [4];
    int unsigned used;
    svn_pkg::svn_out_t exp_item;
    comp[0] = item.d0;
    comp[1] = item.d1;
    comp[2] = item.d2;
    comp[3] = item.d3;
    used = 32'(dims_r);
    if (used < 1) used = 1;
    if (used > svn_pkg::DimsCap) used = svn_pkg::DimsCap;
    sum_sq = '0;
    for (int k = 0; k < 4; k++) begin
      neg[k] = comp[k][31];
      mag[k] = neg[k] ? (32'd0 - comp[k]) : comp[k];
      res[k] = '0;
      if (k < used) sum_sq += 66'(mag[k]) * 66'(mag[k]);
    end
    root = '0;
    for (int b = 34; b >= 0; b--) begin
      cand = root | (35'd1 << b);
      cand_sq = 70'(cand) * 70'(cand);
      if (cand_sq <= 70'(sum_sq)) root = cand;
    end
    if (root == 0) begin
      zero_norms++;
    end else begin
      for (int k = 0; k < used; k++) begin
        quot = (64'(vmax_r) * 64'(mag[k])) / 64'(root);
        res[k] = (neg[k] != mode_r) ? (32'd0 - quot[31:0]) : quot[31:0];
      end
    end
    exp_item.u0 = res[0];
    exp_item.u1 = res[1];
    exp_item.u2 = res[2];
    exp_item.u3 = res[3];
    expected_q.push_back(exp_item);
  endfunction

  function void check_result(svn_pkg::svn_out_t got);
    svn_pkg::svn_out_t want;
    if (expected_q.size() == 0) begin
      $error("unexpected output transaction %h", got);
      errors++;
      return;
    end
    want = expected_q.pop_front();
    checked++;
    if (got.u0 !== want.u0) begin
      $error("u0 mismatch: expected %0d actual %0d", want.u0, got.u0);
      errors++;
    end
    if (got.u1 !== want.u1) begin
      $error("u1 mismatch: expected %0d actual %0d", want.u1, got.u1);
      errors++;
    end
    if (got.u2 !== want.u2) begin
      $error("u2 mismatch: expected %0d actual %0d", want.u2, got.u2);
      errors++;
    end
    if (got.u3 !== want.u3) begin
      $error("u3 mismatch: expected %0d actual %0d", want.u3, got.u3);
      errors++;
    end
  endfunction
endclass

module scaled_vector_normalize_core_tb;
  import svn_pkg::*;

  localparam int unsigned CycleLimit = 2000000;
  localparam logic [CfgIdxW-1:0] RegSpare = 2'd3;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  svn_in_t             in_data;
  logic                out_valid;
  logic                out_stall;
  svn_out_t            out_data;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [VmaxW-1:0]    cfg_wdata;

  norm_scoreboard sb;
  int unsigned cycles;
  int unsigned stall_left;
  bit          quiet;

  scaled_vector_normalize_core dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial sb = new();

  // monitors sample the values from before this edge's updates
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) sb.note_input(in_data);
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
  end

  // consumer stalls in bursts
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (quiet) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= (stall_left > 1);
    end else if ($urandom_range(0, 9) == 0) begin
      stall_left <= $urandom_range(1, 9);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("scaled_vector_normalize_core regression: fail");
      $finish;
    end
  end

  task automatic send_vector(svn_in_t item);
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (in_stall);
  endtask

  // optional idle burst between transactions
  task automatic maybe_gap();
    int unsigned n;
    if (!quiet && $urandom_range(0, 7) == 0) begin
      n = $urandom_range(1, 9);
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [VmaxW-1:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(idx, val);
  endtask

  function automatic logic [31:0] pick_comp();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'd0;
      3: return 32'($signed($urandom_range(0, 262143)) - 131072);
      4: return $urandom_range(0, 1) ? 32'hffff_ffff : 32'd1;
      default: return $urandom;
    endcase
  endfunction

  function automatic svn_in_t pick_vector();
    svn_in_t v;
    v.d0 = pick_comp();
    v.d1 = pick_comp();
    v.d2 = pick_comp();
    v.d3 = pick_comp();
    if ($urandom_range(0, 15) == 0) v = '0;
    return v;
  endfunction

  task automatic directed_part();
    svn_in_t v;
    send_vector('0);
    v = {32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
    send_vector(v);
    v = {32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff};
    send_vector(v);
    v = {32'h7fff_ffff, 32'h8000_0000, 32'h0000_0001, 32'hffff_ffff};
    send_vector(v);
    // zero in the first component, non-zero in the others
    v = {32'h1234_5678, 32'h8000_0000, 32'h0001_0000, 32'h0000_0000};
    send_vector(v);
    v = {32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'hfffe_0000};
    send_vector(v);
    drain();
    write_reg(RegMode, 31'd1);
    write_reg(RegVmax, 31'h7fff_ffff);
    write_reg(RegDims, 31'd1);
    send_vector(v);
    v = {32'h7fff_ffff, 32'h8000_0000, 32'h0000_0003, 32'h8000_0000};
    send_vector(v);
    drain();
    write_reg(RegDims, 31'd0);
    send_vector(v);
    drain();
    write_reg(RegDims, 31'd7);
    write_reg(RegVmax, 31'd0);
    send_vector(v);
    drain();
    write_reg(RegDims, 31'd2);
    write_reg(RegVmax, 31'd1);
    write_reg(RegMode, 31'd0);
    write_reg(RegSpare, 31'h5555_5555);  // unmapped index, ignored
    send_vector(v);
    v = {32'h0000_0000, 32'h0000_0000, 32'hffff_ffff, 32'h0000_0001};
    send_vector(v);
    drain();
  endtask

  initial begin
    int unsigned phases;
    int unsigned per_phase;
    logic [30:0] vm;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_wdata = '0;
    quiet = 1'b0;
    cycles = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    directed_part();
    phases = 13;
    for (int p = 0; p < phases; p++) begin
      case (p % 4)
        0: vm = 31'h7fff_ffff;
        1: vm = 31'd0;
        2: vm = 31'd65536;
        default: vm = 31'($urandom);
      endcase
      write_reg(RegVmax, vm);
      write_reg(RegMode, 31'($urandom_range(0, 1)));
      write_reg(RegDims, 31'(p % 8));
      if (p == phases - 1) quiet = 1'b1;
      per_phase = 100;
      for (int i = 0; i < per_phase; i++) begin
        send_vector(pick_vector());
        maybe_gap();
      end
      drain();
    end
    repeat (80) @(posedge clk);
    if (sb.expected_q.size() != 0) begin
      $error("%0d expected transactions never arrived", sb.expected_q.size());
      sb.errors++;
    end
    $display("checked %0d output transactions (%0d with zero norm) over %0d settings",
             sb.checked, sb.zero_norms, phases + 5);
    $display("covered vmax extremes, both modes and dims_used 0 to 7 with random stalls");
    if (sb.errors == 0) begin
      $display("scaled_vector_normalize_core regression: pass");
    end else begin
      $display("scaled_vector_normalize_core regression: fail");
    end
    $finish;
  end
endmodule

`default_nettype wire

[files.f]
hdl/svn_pkg.sv
hdl/scaled_vector_normalize_core.sv
tb/sv/scaled_vector_normalize_core_tb.sv
